[sv/mr_pkg.sv]
// ----------------------------------------------------------------------------
// mr_pkg
// Shared types, constants and helpers for the Miller-Rabin prime tester.
// ----------------------------------------------------------------------------
package mr_pkg;

	localparam int unsigned N_W   = 32;
	localparam int unsigned CNT_W = $clog2(N_W);

	localparam logic [N_W-1:0] LIMIT_TWO   = N_W'(32'd1373653);
	localparam logic [N_W-1:0] LIMIT_THREE = N_W'(32'd25326001);
	localparam logic [N_W-1:0] LIMIT_FOUR  = N_W'(32'd3215031751);

	// witnesses are all below eight
	localparam int unsigned WIT_W = 3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_SPLIT,
		ST_WITNESS,
		ST_POW_CHECK,
		ST_POW_RES,
		ST_POW_BASE,
		ST_SQ_CHECK,
		ST_SQ_WAIT,
		ST_FINISH
	} mr_state_t;

	function automatic logic [WIT_W-1:0] witness_value(input logic [1:0] idx);
		logic [WIT_W-1:0] w;
		case (idx)
			2'd0:    w = WIT_W'(3'd2);
			2'd1:    w = WIT_W'(3'd3);
			2'd2:    w = WIT_W'(3'd5);
			2'd3:    w = WIT_W'(3'd7);
			default: w = WIT_W'(3'd2);
		endcase
		return w;
	endfunction

	// a mod m for a below eight and m at least three: two subtractions suffice
	function automatic logic [WIT_W-1:0] small_mod(input logic [WIT_W-1:0] a,
		input logic [WIT_W-1:0] m);
		logic [WIT_W-1:0] r;
		r = a;
		if (r >= m) begin
			r = r - m;
		end
		if (r >= m) begin
			r = r - m;
		end
		return r;
	endfunction

endpackage

[sv/mr_modmul.sv]
// ----------------------------------------------------------------------------
// mr_modmul
// Bit-serial interleaved modular multiplier: (mplr * mcand) mod modulus,
// one multiplier bit per cycle, MSB first. Both operands must be below the
// modulus.
// ----------------------------------------------------------------------------
module mr_modmul
	import mr_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] mplr,
	input  logic [N_W-1:0] mcand,
	input  logic [N_W-1:0] modulus,
	output logic           done,
	output logic [N_W-1:0] product
);

	logic [N_W-1:0]   acc_q;
	logic [N_W-1:0]   mplr_q;
	logic [N_W-1:0]   mcand_q;
	logic [N_W-1:0]   mod_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [N_W:0]   dbl;
	logic [N_W:0]   dbl_red;
	logic [N_W:0]   sum;
	logic [N_W:0]   sum_red;
	logic [N_W-1:0] addend;

	// acc <- (2*acc + bit*mcand) mod m, reduced after each of the two adds
	always_comb begin
		dbl = {acc_q, 1'b0};
		if (dbl >= {1'b0, mod_q}) begin
			dbl_red = dbl - {1'b0, mod_q};
		end else begin
			dbl_red = dbl;
		end
		addend = mplr_q[N_W-1] ? mcand_q : '0;
		sum    = {1'b0, dbl_red[N_W-1:0]} + {1'b0, addend};
		if (sum >= {1'b0, mod_q}) begin
			sum_red = sum - {1'b0, mod_q};
		end else begin
			sum_red = sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(N_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q   <= '0;
			mplr_q  <= mplr;
			mcand_q <= mcand;
			mod_q   <= modulus;
		end else if (busy_q) begin
			acc_q  <= sum_red[N_W-1:0];
			mplr_q <= {mplr_q[N_W-2:0], 1'b0};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

[sv/miller_rabin_prime_test.sv]
// out_valid is registered from FINISH, which follows CLASSIFY directly for
// out-of-range, zero, one and even candidates; odd ones take at most 62
// modular multiplies per witness, with up to four witnesses.
// One candidate at a time; the bit-serial modular multiplier (one bit per
// cycle) sets the rate. A new candidate is taken while a result waits.
// Reset (arst_n, asynchronous, active low) returns to idle with no result held.
// ----------------------------------------------------------------------------
// miller_rabin_prime_test
// Deterministic Miller-Rabin primality test for 32-bit candidates below
// 3215031751 (larger ones flag out_of_range), with witnesses 2,3,5,7 chosen by the size of the candidate.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test
	import mr_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [N_W-1:0] candidate,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           is_prime,
	output logic           out_of_range
);

	mr_state_t state_q, state_d;

	logic [N_W-1:0]   n_q;
	logic [N_W-1:0]   d_q;
	logic [N_W-1:0]   exp_q;
	logic [N_W-1:0]   res_q;
	logic [N_W-1:0]   base_q;
	logic [CNT_W-1:0] s_q;
	logic [CNT_W-1:0] r_q;
	logic [2:0]       wit_q;
	logic [2:0]       wcount_q;
	logic             prime_q;
	logic             oor_q;

	logic             out_valid_q;
	logic             is_prime_q;
	logic             out_of_range_q;

	logic             mul_start;
	logic [N_W-1:0]   mul_a;
	logic [N_W-1:0]   mul_b;
	logic             mul_done;
	logic [N_W-1:0]   mul_prod;

	logic [N_W-1:0]   n_minus1;
	logic [WIT_W-1:0] wit_val;
	logic             wit_is_n;
	logic             out_load;

	assign n_minus1 = n_q - N_W'(1);
	assign wit_val  = witness_value(wit_q[1:0]);
	assign wit_is_n = (n_q == N_W'(wit_val));
	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	mr_modmul u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mplr    (mul_a),
		.mcand   (mul_b),
		.modulus (n_q),
		.done    (mul_done),
		.product (mul_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		mul_a     = res_q;
		mul_b     = base_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_CLASSIFY;
				end
			end
			ST_CLASSIFY: begin
				if (n_q >= LIMIT_FOUR || n_q < N_W'(2) || !n_q[0]) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_SPLIT;
				end
			end
			ST_SPLIT: begin
				if (d_q[0]) begin
					state_d = ST_WITNESS;
				end
			end
			ST_WITNESS: begin
				if (wit_q == wcount_q) begin
					state_d = ST_FINISH;
				end else if (!wit_is_n) begin
					state_d = ST_POW_CHECK;
				end
			end
			ST_POW_CHECK: begin
				if (exp_q == '0) begin
					if (res_q == N_W'(1) || res_q == n_minus1) begin
						state_d = ST_WITNESS;
					end else begin
						state_d = ST_SQ_CHECK;
					end
				end else if (exp_q[0]) begin
					mul_start = 1'b1;
					state_d   = ST_POW_RES;
				end else begin
					mul_start = 1'b1;
					mul_a     = base_q;
					state_d   = ST_POW_BASE;
				end
			end
			ST_POW_RES: begin
				// chain straight into the base squaring
				mul_a = base_q;
				if (mul_done) begin
					mul_start = 1'b1;
					state_d   = ST_POW_BASE;
				end
			end
			ST_POW_BASE: begin
				if (mul_done) begin
					state_d = ST_POW_CHECK;
				end
			end
			ST_SQ_CHECK: begin
				mul_b = res_q;
				if (r_q < s_q) begin
					mul_start = 1'b1;
					state_d   = ST_SQ_WAIT;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_SQ_WAIT: begin
				if (mul_done) begin
					if (mul_prod == n_minus1) begin
						state_d = ST_WITNESS;
					end else begin
						state_d = ST_SQ_CHECK;
					end
				end
			end
			ST_FINISH: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				n_q <= candidate;
			end
			ST_CLASSIFY: begin
				oor_q    <= (n_q >= LIMIT_FOUR);
				prime_q  <= (n_q == N_W'(2));
				d_q      <= n_minus1;
				s_q      <= '0;
				wit_q    <= '0;
				if (n_q < LIMIT_TWO) begin
					wcount_q <= 3'd2;
				end else if (n_q < LIMIT_THREE) begin
					wcount_q <= 3'd3;
				end else begin
					wcount_q <= 3'd4;
				end
			end
			ST_SPLIT: begin
				if (!d_q[0]) begin
					d_q <= {1'b0, d_q[N_W-1:1]};
					s_q <= s_q + CNT_W'(1);
				end
			end
			ST_WITNESS: begin
				if (wit_q == wcount_q) begin
					prime_q <= 1'b1;
				end else if (wit_is_n) begin
					wit_q <= wit_q + 3'd1;
				end else begin
					res_q <= N_W'(1);
					exp_q <= d_q;
					if (n_q < N_W'(8)) begin
						base_q <= N_W'(small_mod(wit_val, n_q[WIT_W-1:0]));
					end else begin
						base_q <= N_W'(wit_val);
					end
				end
			end
			ST_POW_CHECK: begin
				if (exp_q == '0) begin
					if (res_q == N_W'(1) || res_q == n_minus1) begin
						wit_q <= wit_q + 3'd1;
					end
					r_q <= CNT_W'(1);
				end
			end
			ST_POW_RES: begin
				if (mul_done) begin
					res_q <= mul_prod;
				end
			end
			ST_POW_BASE: begin
				if (mul_done) begin
					base_q <= mul_prod;
					exp_q  <= {1'b0, exp_q[N_W-1:1]};
				end
			end
			ST_SQ_CHECK: begin
				if (r_q >= s_q) begin
					prime_q <= 1'b0;
				end
			end
			ST_SQ_WAIT: begin
				if (mul_done) begin
					res_q <= mul_prod;
					r_q   <= r_q + CNT_W'(1);
					if (mul_prod == n_minus1) begin
						wit_q <= wit_q + 3'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// result register: the core may pick up a new transaction while it waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			is_prime_q     <= prime_q && !oor_q;
			out_of_range_q <= oor_q;
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign is_prime     = is_prime_q;
	assign out_of_range = out_of_range_q;

endmodule

[bench/miller_rabin_prime_test_tb.sv]
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_tb
// Checks the prime tester against a behavioural Miller-Rabin predictor:
// directed corner candidates, then random phases with sender and receiver
// back-pressure, draining between phases.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test_tb
	import mr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [N_W-1:0] TRIAL_BASES [4] = '{32'd2, 32'd3, 32'd5, 32'd7};

	localparam logic [N_W-1:0] CORNERS [24] = '{
		32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd9, 32'd25, 32'd49,
		32'd561, 32'd2047, 32'd65537, 32'd1373651, 32'd1373653, 32'd25326001,
		32'd2147483647, 32'd3215031749, 32'd3215031750, 32'd3215031751,
		32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd1373652
	};

	class verdict_scoreboard;
		typedef struct packed {
			logic is_prime;
			logic out_of_range;
		} verdict_t;

		verdict_t    pending[$];
		int unsigned mismatches = 0;

		function logic [N_W-1:0] mul_mod(logic [N_W-1:0] a, logic [N_W-1:0] b,
			logic [N_W-1:0] m);
			logic [63:0] p;
			p = {32'd0, a} * {32'd0, b};
			return N_W'(p % {32'd0, m});
		endfunction

		function logic [N_W-1:0] pow_mod(logic [N_W-1:0] base, logic [N_W-1:0] e,
			logic [N_W-1:0] m);
			logic [N_W-1:0] r;
			logic [N_W-1:0] b;
			r = 1 % m;
			b = base % m;
			while (e != 0) begin
				if (e[0])
					r = mul_mod(r, b, m);
				b = mul_mod(b, b, m);
				e = e >> 1;
			end
			return r;
		endfunction

		// n odd and at least three
		function bit strong_probable(logic [N_W-1:0] n, logic [N_W-1:0] d, int unsigned s,
			logic [N_W-1:0] a);
			logic [N_W-1:0] x;
			if (a % n == 0)
				return 1'b1;
			x = pow_mod(a, d, n);
			if (x == 1 || x == n - 1)
				return 1'b1;
			for (int unsigned r = 1; r < s; r++) begin
				x = mul_mod(x, x, n);
				if (x == n - 1)
					return 1'b1;
			end
			return 1'b0;
		endfunction

		function verdict_t predict_verdict(logic [N_W-1:0] n);
			verdict_t    v;
			logic [N_W-1:0] d;
			int unsigned s;
			int unsigned bases;
			v = '0;
			if (n >= LIMIT_FOUR) begin
				v.out_of_range = 1'b1;
				return v;
			end
			if (n < 2)
				return v;
			if (!n[0]) begin
				v.is_prime = (n == 2);
				return v;
			end
			bases = (n < LIMIT_TWO) ? 2 : (n < LIMIT_THREE) ? 3 : 4;
			d = n - 1;
			s = 0;
			while (!d[0]) begin
				d = d >> 1;
				s++;
			end
			for (int i = 0; i < bases; i++)
				if (!strong_probable(n, d, s, TRIAL_BASES[i]))
					return v;
			v.is_prime = 1'b1;
			return v;
		endfunction

		function void note_candidate(logic [N_W-1:0] n);
			pending.push_back(predict_verdict(n));
		endfunction

		function void check_verdict(logic prime, logic oor);
			verdict_t want;
			if (pending.size() == 0) begin
				$display("%0t unexpected result is_prime=%0b out_of_range=%0b",
					$time, prime, oor);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			if (prime !== want.is_prime) begin
				$display("%0t is_prime expected %0b actual %0b", $time, want.is_prime, prime);
				mismatches++;
			end
			if (oor !== want.out_of_range) begin
				$display("%0t out_of_range expected %0b actual %0b",
					$time, want.out_of_range, oor);
				mismatches++;
			end
		endfunction
	endclass

	logic           clk          = 1'b0;
	logic           arst_n       = 1'b0;
	logic           in_valid     = 1'b0;
	logic           in_ready;
	logic [N_W-1:0] candidate    = '0;
	logic           out_valid;
	logic           out_ready    = 1'b0;
	logic           is_prime;
	logic           out_of_range;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;

	verdict_scoreboard sb = new;

	miller_rabin_prime_test u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.candidate   (candidate),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.is_prime    (is_prime),
		.out_of_range(out_of_range)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_verdict(is_prime, out_of_range);
	end

	// one input transaction; idle cycles rolled before valid goes up
	task automatic send_candidate(logic [N_W-1:0] n);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		candidate <= n;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_candidate(n);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	// search for a prime in [lo, hi] by trial draws of odd numbers
	function automatic logic [N_W-1:0] draw_prime(logic [N_W-1:0] lo, logic [N_W-1:0] hi);
		logic [N_W-1:0] n;
		verdict_scoreboard::verdict_t v;
		n = 32'd3;
		repeat (1000) begin
			n = $urandom_range(hi, lo) | 32'd1;
			v = sb.predict_verdict(n);
			if (v.is_prime)
				break;
		end
		return n;
	endfunction

	// mostly cheap or small candidates; large primes are the slow case
	function automatic logic [N_W-1:0] draw_candidate();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 8)
			return $urandom & ~32'd1;
		else if (roll < 16)
			return $urandom_range(32'hFFFF_FFFF, LIMIT_FOUR);
		else if (roll < 20)
			return $urandom_range(1);
		else if (roll < 45)
			return $urandom_range(65535, 3) | 32'd1;
		else if (roll < 70)
			return $urandom_range(LIMIT_FOUR - 1, 3) | 32'd1;
		else if (roll < 90)
			return draw_prime(32'd3, 32'd65535);
		else if (roll < 95)
			return draw_prime(LIMIT_TWO, LIMIT_THREE - 1);
		else
			return draw_prime(LIMIT_THREE, LIMIT_FOUR - 2);
	endfunction

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (CORNERS[i])
			send_candidate(CORNERS[i]);
		drain_results();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 73;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 73;
				end
				default: begin
					send_idle_pct  = 23;
					recv_stall_pct = 23;
				end
			endcase
			repeat (72)
				send_candidate(draw_candidate());
			drain_results();
		end

		// catch any stray result
		repeat (50) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#200ms;
		$display("tb: failure");
		$finish;
	end

endmodule
